### src/crc32_pkg.sv
// Package: constants and the byte-wide update function for the reflected CRC-32.
`timescale 1ns / 1ps

package crc32_pkg;

    localparam int unsigned CrcWidth  = 32;
    localparam int unsigned ByteWidth = 8;

    localparam logic [CrcWidth-1:0] CRC_POLY = 32'hEDB8_8320;

    // Feedback test bit used for the eight shift steps.
    typedef enum logic {
        FB_BIT0 = 1'b0,
        FB_BIT1 = 1'b1
    } t_fb_mode;

    // Eight reflected shift/xor steps; the test bit is bit 0 or bit 1 by mode.
    function automatic logic [CrcWidth-1:0] crc_shift8(
        input logic [CrcWidth-1:0] v_in,
        input t_fb_mode            mode
    );
        logic [CrcWidth-1:0] v;
        logic                fb;
        v = v_in;
        for (int i = 0; i < ByteWidth; i++) begin
            fb = (mode == FB_BIT1) ? v[1] : v[0];
            if (fb) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

endpackage

### src/crc32_reflected_byte_stream_top.sv
// A closing byte is held in the input register, then its CRC in the result register.
// One byte per cycle unless a closing byte waits; CRC feedback runs eight unrolled steps.
// An input register and a result register part the two channels, so bytes that do not close
// a message keep flowing while a finished CRC waits; a closing byte waits until it is taken.
// Reset (synchronous, active low) clears the CRC register, the mode and both valid flags.
`timescale 1ns / 1ps

module crc32_reflected_byte_stream_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [crc32_pkg::ByteWidth-1:0] i_data_byte,
    input  logic                            i_first_of_message,
    input  logic                            i_last_of_message,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [crc32_pkg::CrcWidth-1:0]  o_crc_value
);
    import crc32_pkg::*;

    t_fb_mode                r_mode;
    logic                    r_in_valid;
    logic [ByteWidth-1:0]    r_in_byte;
    logic                    r_in_first;
    logic                    r_in_last;
    logic [CrcWidth-1:0]     r_crc;
    logic [CrcWidth-1:0]     n_crc;
    logic                    r_out_valid;
    logic [CrcWidth-1:0]     r_out_crc;

    logic                    in_accept;
    logic                    out_free;
    logic                    advance;
    logic [CrcWidth-1:0]     crc_base;
    logic [CrcWidth-1:0]     folded;

    assign out_free   = !r_out_valid || i_out_ready;
    // A byte that closes a message can only move on when the result register has room.
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_in_ready = !r_in_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    always_comb begin
        crc_base = r_in_first ? '0 : r_crc;
        folded   = {{(CrcWidth-ByteWidth){1'b0}}, r_in_byte ^ crc_base[ByteWidth-1:0]};
        n_crc    = crc_shift8(folded, r_mode) ^ (crc_base >> ByteWidth);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= FB_BIT0;
            r_in_valid  <= 1'b0;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= t_fb_mode'(i_cfg_wdata);
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_crc <= n_crc;
            end
            if (advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte  <= i_data_byte;
            r_in_first <= i_first_of_message;
            r_in_last  <= i_last_of_message;
        end
        if (advance && r_in_last) begin
            r_out_crc <= n_crc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_crc_value = r_out_crc;

endmodule

### src/crc32_checker.sv
// Checker: port-level assertions for the CRC-32 byte stream, bound to the top level.
`timescale 1ns / 1ps

module crc32_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_first_of_message,
    input logic        i_last_of_message,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_crc_value
);

    logic in_accept;
    assign in_accept = i_in_valid && o_in_ready;

    // A result that is offered stays offered, unchanged, until its transaction.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_crc_value))
        else $error("result changed or withdrawn before its transaction");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // With the result register empty the input side can never be stalled.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while result register empty");

    // A one-byte message of zero gives a zero CRC in either mode, offered from the result register.
    a_zero_message: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_first_of_message && i_last_of_message && (i_data_byte == 8'h00)
            && !o_out_valid ##1 !o_out_valid
        |=> o_out_valid && (o_crc_value == 32'h0000_0000))
        else $error("wrong or missing result for a single zero byte");

endmodule

bind crc32_reflected_byte_stream_top crc32_checker u_crc32_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .i_data_byte        (i_data_byte),
    .i_first_of_message (i_first_of_message),
    .i_last_of_message  (i_last_of_message),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_crc_value        (o_crc_value)
);

### tb/crc32_reflected_byte_stream_top_tb.sv
// Self-checking testbench for the byte-serial reflected CRC-32 block.
`timescale 1ns / 1ps

module crc32_reflected_byte_stream_top_tb;

    import crc32_pkg::*;

    localparam int unsigned ClkHalf      = 4;
    localparam int unsigned SettleCycles = 8;
    localparam int unsigned StallLimit   = 1000;
    localparam int unsigned HalfPhaseLen = 317;
    localparam int unsigned DirCount     = 23;

    typedef struct packed {
        t_fb_mode            mode;
        logic [ByteWidth-1:0] byte_val;
        logic                is_first;
        logic                is_last;
        logic                fixed_en;
        logic [CrcWidth-1:0] fixed_crc;
    } t_dir_row;

    // Rows with fixed_en set carry a CRC that can be worked out by hand; the rest are
    // checked against the running prediction.
    localparam t_dir_row DirRows [DirCount] = '{
        '{FB_BIT0, 8'h00, 1'b1, 1'b1, 1'b1, 32'h0000_0000},
        '{FB_BIT0, 8'h80, 1'b1, 1'b1, 1'b1, 32'hEDB8_8320},
        '{FB_BIT0, 8'h01, 1'b1, 1'b1, 1'b1, 32'h7707_3096},
        '{FB_BIT0, 8'hFF, 1'b1, 1'b1, 1'b0, 32'h0000_0000},
        '{FB_BIT0, 8'h31, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
        '{FB_BIT0, 8'h32, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
        '{FB_BIT0, 8'h33, 1'b0, 1'b1, 1'b0, 32'h0000_0000},
        '{FB_BIT0, 8'hA5, 1'b0, 1'b1, 1'b0, 32'h0000_0000},
        '{FB_BIT0, 8'h5A, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
        '{FB_BIT0, 8'hC3, 1'b1, 1'b1, 1'b0, 32'h0000_0000},
        '{FB_BIT0, 8'h7E, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
        '{FB_BIT0, 8'h00, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
        '{FB_BIT0, 8'hFF, 1'b0, 1'b1, 1'b0, 32'h0000_0000},
        '{FB_BIT1, 8'h00, 1'b1, 1'b1, 1'b1, 32'h0000_0000},
        '{FB_BIT1, 8'h80, 1'b1, 1'b1, 1'b0, 32'h0000_0000},
        '{FB_BIT1, 8'hFF, 1'b1, 1'b1, 1'b0, 32'h0000_0000},
        '{FB_BIT1, 8'h02, 1'b1, 1'b1, 1'b0, 32'h0000_0000},
        '{FB_BIT1, 8'h12, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
        '{FB_BIT1, 8'h34, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
        '{FB_BIT1, 8'h56, 1'b0, 1'b1, 1'b0, 32'h0000_0000},
        '{FB_BIT1, 8'h9C, 1'b0, 1'b1, 1'b0, 32'h0000_0000},
        '{FB_BIT1, 8'hAA, 1'b1, 1'b0, 1'b0, 32'h0000_0000},
        '{FB_BIT1, 8'h55, 1'b0, 1'b1, 1'b0, 32'h0000_0000}
    };

    logic                 i_clk              = 1'b0;
    logic                 i_rst_n            = 1'b0;
    logic                 i_cfg_we           = 1'b0;
    logic                 i_cfg_wdata        = 1'b0;
    logic                 i_in_valid         = 1'b0;
    logic                 o_in_ready;
    logic [ByteWidth-1:0] i_data_byte        = '0;
    logic                 i_first_of_message = 1'b0;
    logic                 i_last_of_message  = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready        = 1'b0;
    logic [CrcWidth-1:0]  o_crc_value;

    logic [CrcWidth-1:0] running_crc   = '0;
    t_fb_mode            feedback_mode = FB_BIT0;
    logic [CrcWidth-1:0] pending_crcs [$];
    logic                drv_fixed_en  = 1'b0;
    logic [CrcWidth-1:0] drv_fixed_crc = '0;

    int unsigned error_count       = 0;
    int unsigned bytes_taken       = 0;
    int unsigned crcs_checked      = 0;
    int unsigned quiet_cycles      = 0;
    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_idle_pct = 0;

    crc32_reflected_byte_stream_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_data_byte        (i_data_byte),
        .i_first_of_message (i_first_of_message),
        .i_last_of_message  (i_last_of_message),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_crc_value        (o_crc_value)
    );

    always begin
        #ClkHalf i_clk = 1'b1;
        #ClkHalf i_clk = 1'b0;
    end

    // Folds one message byte into the running CRC: the low byte goes through eight
    // reflected steps, then the register shifted down by eight is xored back in.
    function automatic logic [CrcWidth-1:0] fold_byte(
        input logic [CrcWidth-1:0]  crc,
        input logic [ByteWidth-1:0] msg_byte,
        input t_fb_mode             mode
    );
        logic [CrcWidth-1:0] v;
        logic                tap;
        v = {24'd0, msg_byte ^ crc[7:0]};
        for (int k = 0; k < ByteWidth; k++) begin
            tap = (mode == FB_BIT1) ? v[1] : v[0];
            v = {1'b0, v[CrcWidth-1:1]} ^ (tap ? CRC_POLY : '0);
        end
        return v ^ {8'd0, crc[CrcWidth-1:8]};
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Both channels are observed in one process, so a CRC is always queued before it
    // can be taken off the output.
    always @(posedge i_clk) begin
        logic [CrcWidth-1:0] want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_crcs.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected CRC transaction, expected none, actual %08h",
                             $time, o_crc_value);
                end else begin
                    want = pending_crcs.pop_front();
                    crcs_checked++;
                    if (o_crc_value !== want) begin
                        error_count++;
                        $display("%0t: crc_value mismatch, expected %08h, actual %08h",
                                 $time, want, o_crc_value);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                bytes_taken++;
                if (i_first_of_message) begin
                    running_crc = '0;
                end
                running_crc = fold_byte(running_crc, i_data_byte, feedback_mode);
                if (i_last_of_message) begin
                    pending_crcs.push_back(drv_fixed_en ? drv_fixed_crc : running_crc);
                end
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= StallLimit) begin
                $display("%0t: no transaction for %0d cycles, %0d CRCs outstanding",
                         $time, quiet_cycles, pending_crcs.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(
        input logic [ByteWidth-1:0] msg_byte,
        input logic                 is_first,
        input logic                 is_last,
        input logic                 fixed_en,
        input logic [CrcWidth-1:0]  fixed_crc
    );
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid         = 1'b1;
        i_data_byte        = msg_byte;
        i_first_of_message = is_first;
        i_last_of_message  = is_last;
        drv_fixed_en       = fixed_en;
        drv_fixed_crc      = fixed_crc;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Bytes without a last flag give no result, so the task idles on after the queue empties
    // to let them leave the pipeline before the mode may change.
    task automatic settle_idle();
        i_in_valid = 1'b0;
        while (pending_crcs.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_mode(input t_fb_mode mode);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = mode;
        @(negedge i_clk);
        i_cfg_we      = 1'b0;
        feedback_mode = mode;
    endtask

    // Mostly well-formed messages; some lose their first flag, and some carry random flags.
    task automatic send_random_messages(input int unsigned byte_count);
        int unsigned sent;
        int unsigned msg_len;
        int unsigned shape;
        logic        is_first;
        logic        is_last;
        sent = 0;
        while (sent < byte_count) begin
            shape   = $urandom_range(99);
            msg_len = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 8);
            for (int j = 0; j < msg_len; j++) begin
                is_first = (j == 0);
                is_last  = (j == msg_len - 1);
                if (shape < 10) begin
                    is_first = 1'($urandom_range(1));
                    is_last  = 1'($urandom_range(1));
                end else if (shape < 18 && j == 0) begin
                    is_first = 1'b0;
                end
                send_byte(8'($urandom_range(255)), is_first, is_last, 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial begin
        sender_idle_pct   = 22;
        receiver_idle_pct = 67;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < DirCount; r++) begin
            if (DirRows[r].mode != feedback_mode) begin
                settle_idle();
                write_mode(DirRows[r].mode);
            end
            send_byte(DirRows[r].byte_val, DirRows[r].is_first, DirRows[r].is_last,
                      DirRows[r].fixed_en, DirRows[r].fixed_crc);
        end

        for (int p = 0; p < 3; p++) begin
            sender_idle_pct   = (p == 0) ? 22 : (p == 1) ? 67 : 0;
            receiver_idle_pct = (p == 0) ? 67 : (p == 1) ? 22 : 0;
            for (int h = 0; h < 2; h++) begin
                settle_idle();
                write_mode((h != 0) ? FB_BIT1 : FB_BIT0);
                send_random_messages(HalfPhaseLen);
            end
        end
        settle_idle();

        $display("Covered %0d byte transactions and %0d CRC results in both feedback modes,",
                 bytes_taken, crcs_checked);
        $display("under sender and receiver stalls and at full rate; %0d errors.", error_count);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### crc32_reflected_byte_stream_top.f
src/crc32_pkg.sv
src/crc32_reflected_byte_stream_top.sv
src/crc32_checker.sv
tb/crc32_reflected_byte_stream_top_tb.sv
